// ----- sv/tcat_pkg.sv -----
// ----------------------------------------------------------------------------
// tcat_pkg
// Shared types and constants for the touch calibrate and track unit.
// ----------------------------------------------------------------------------
package tcat_pkg;

  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HORIZ_MIN     = 3'd0,
    REG_HORIZ_MAX     = 3'd1,
    REG_VERT_MIN      = 3'd2,
    REG_VERT_MAX      = 3'd3,
    REG_SCREEN_WIDTH  = 3'd4,
    REG_SCREEN_HEIGHT = 3'd5,
    REG_ORIENTATION   = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_NONE    = 2'd0,
    ST_EVENT   = 2'd1,
    ST_BAD_CAL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PH_DOWN = 2'd0,
    PH_MOVE = 2'd1,
    PH_UP   = 2'd2
  } phase_t;

  localparam int unsigned ORI_W      = 3;
  localparam int unsigned ORI_SWAP   = 0;
  localparam int unsigned ORI_INV_H  = 1;
  localparam int unsigned ORI_INV_V  = 2;

  localparam int unsigned RST_RAW_MAX = 4095;
  localparam int unsigned RST_WIDTH   = 320;
  localparam int unsigned RST_HEIGHT  = 240;

  typedef struct packed {
    logic busy;
    logic inwin;
  } lane_stat_t;

endpackage

// ----- sv/tcat_in_if.sv -----
// ----------------------------------------------------------------------------
// tcat_in_if
// Sample channel: pen flag and raw X/Y readings with valid/ready.
// ----------------------------------------------------------------------------
interface tcat_in_if #(
  parameter int unsigned RAW_BITS = 12
);
  logic                valid;
  logic                ready;
  logic                touching;
  logic [RAW_BITS-1:0] raw_x;
  logic [RAW_BITS-1:0] raw_y;

  modport source (output valid, touching, raw_x, raw_y, input ready);
  modport sink   (input valid, touching, raw_x, raw_y, output ready);
endinterface

// ----- sv/tcat_out_if.sv -----
// ----------------------------------------------------------------------------
// tcat_out_if
// Event channel: status, phase and logical position with valid/ready.
// ----------------------------------------------------------------------------
interface tcat_out_if
  import tcat_pkg::*;
#(
  parameter int unsigned POS_BITS = 12
);
  logic                valid;
  logic                ready;
  status_t             status;
  phase_t              phase;
  logic [POS_BITS-1:0] pos_x;
  logic [POS_BITS-1:0] pos_y;

  modport source (output valid, status, phase, pos_x, pos_y, input ready);
  modport sink   (input valid, status, phase, pos_x, pos_y, output ready);
endinterface

// ----- sv/touch_calibrate_and_track_unit.sv -----
// ----------------------------------------------------------------------------
// touch_calibrate_and_track_unit
// Flow: idle takes a sample; a touching sample with a valid calibration
//   starts both axis lanes, others skip them; merge loads the event register.
// Throughput: one sample at a time, bound by the one-bit-per-cycle divider
//   in each axis lane; the next sample is taken while the previous event
//   still waits in the output register.
// Reset: synchronous rst_n restores register defaults, pen inactive, last
//   position zero.
// ----------------------------------------------------------------------------
module touch_calibrate_and_track_unit
  import tcat_pkg::*;
#(
  parameter int unsigned RAW_BITS = 12,
  parameter int unsigned POS_BITS = 12,
  localparam int unsigned CFG_W = (RAW_BITS > POS_BITS + 1) ? RAW_BITS : POS_BITS + 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  tcat_in_if.sink              in_ch,
  tcat_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_MERGE
  } state_t;

  state_t              state_r;
  logic [RAW_BITS-1:0] hmin_r, hmax_r, vmin_r, vmax_r;
  logic [POS_BITS:0]   width_r, height_r;
  logic [ORI_W-1:0]    orient_r;
  logic                pen_r;
  logic [POS_BITS-1:0] last_x_r, last_y_r;
  logic                bad_r;
  logic                touch_r;
  logic                out_valid_r;
  status_t             out_status_r;
  phase_t              out_phase_r;
  logic [POS_BITS-1:0] out_x_r, out_y_r;

  logic                in_fire;
  logic                bad_cal;
  logic                lane_start;
  logic                swap;
  logic [RAW_BITS-1:0] hraw, vraw;
  lane_stat_t          h_stat, v_stat;
  logic [POS_BITS-1:0] h_pos, v_pos;
  logic                out_free;
  logic                ok;
  status_t             status_nxt;
  phase_t              phase_nxt;
  logic [POS_BITS-1:0] x_nxt, y_nxt;
  logic                pen_nxt;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign bad_cal     = (hmin_r >= hmax_r) || (vmin_r >= vmax_r) ||
                       (width_r == '0) || (height_r == '0);
  assign lane_start  = in_fire && !bad_cal && in_ch.touching;
  assign swap        = orient_r[ORI_SWAP];
  assign hraw        = swap ? in_ch.raw_y : in_ch.raw_x;
  assign vraw        = swap ? in_ch.raw_x : in_ch.raw_y;

  tcat_lane #(.RAW_BITS(RAW_BITS), .POS_BITS(POS_BITS)) u_lane_h (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (lane_start),
    .raw    (hraw),
    .lo     (hmin_r),
    .hi     (hmax_r),
    .ext    (width_r),
    .mirror (orient_r[ORI_INV_H]),
    .stat   (h_stat),
    .pos    (h_pos)
  );

  tcat_lane #(.RAW_BITS(RAW_BITS), .POS_BITS(POS_BITS)) u_lane_v (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (lane_start),
    .raw    (vraw),
    .lo     (vmin_r),
    .hi     (vmax_r),
    .ext    (height_r),
    .mirror (orient_r[ORI_INV_V]),
    .stat   (v_stat),
    .pos    (v_pos)
  );

  // merge the two lanes into one event
  assign ok       = touch_r && h_stat.inwin && v_stat.inwin;
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    status_nxt = ST_NONE;
    phase_nxt  = PH_DOWN;
    x_nxt      = '0;
    y_nxt      = '0;
    pen_nxt    = pen_r;
    if (bad_r) begin
      status_nxt = ST_BAD_CAL;
    end else if (!ok) begin
      if (pen_r) begin
        status_nxt = ST_EVENT;
        phase_nxt  = PH_UP;
        x_nxt      = last_x_r;
        y_nxt      = last_y_r;
        pen_nxt    = 1'b0;
      end
    end else begin
      status_nxt = ST_EVENT;
      phase_nxt  = pen_r ? PH_MOVE : PH_DOWN;
      x_nxt      = h_pos;
      y_nxt      = v_pos;
      pen_nxt    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hmin_r      <= '0;
      hmax_r      <= RAW_BITS'(RST_RAW_MAX);
      vmin_r      <= '0;
      vmax_r      <= RAW_BITS'(RST_RAW_MAX);
      width_r     <= (POS_BITS + 1)'(RST_WIDTH);
      height_r    <= (POS_BITS + 1)'(RST_HEIGHT);
      orient_r    <= '0;
      state_r     <= S_IDLE;
      pen_r       <= 1'b0;
      last_x_r    <= '0;
      last_y_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_idx))
          REG_HORIZ_MIN:     hmin_r   <= cfg_wdata[RAW_BITS-1:0];
          REG_HORIZ_MAX:     hmax_r   <= cfg_wdata[RAW_BITS-1:0];
          REG_VERT_MIN:      vmin_r   <= cfg_wdata[RAW_BITS-1:0];
          REG_VERT_MAX:      vmax_r   <= cfg_wdata[RAW_BITS-1:0];
          REG_SCREEN_WIDTH:  width_r  <= cfg_wdata[POS_BITS:0];
          REG_SCREEN_HEIGHT: height_r <= cfg_wdata[POS_BITS:0];
          REG_ORIENTATION:   orient_r <= cfg_wdata[ORI_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_r && out_ch.ready && (state_r != S_MERGE)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            bad_r   <= bad_cal;
            touch_r <= in_ch.touching;
            state_r <= lane_start ? S_RUN : S_MERGE;
          end
        end
        S_RUN: begin
          if (!h_stat.busy && !v_stat.busy) begin
            state_r <= S_MERGE;
          end
        end
        S_MERGE: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= status_nxt;
            out_phase_r  <= phase_nxt;
            out_x_r      <= x_nxt;
            out_y_r      <= y_nxt;
            pen_r        <= pen_nxt;
            if (!bad_r && ok) begin
              last_x_r <= x_nxt;
              last_y_r <= y_nxt;
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.phase  = out_phase_r;
  assign out_ch.pos_x  = out_x_r;
  assign out_ch.pos_y  = out_y_r;

endmodule

// ----- sv/tcat_lane.sv -----
// ----------------------------------------------------------------------------
// tcat_lane
// One axis: window check, optional mirror, multiply by extent-1, then a
// shift-subtract divide by the span, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tcat_lane
  import tcat_pkg::*;
#(
  parameter int unsigned RAW_BITS = 12,
  parameter int unsigned POS_BITS = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [RAW_BITS-1:0] raw,
  input  logic [RAW_BITS-1:0] lo,
  input  logic [RAW_BITS-1:0] hi,
  input  logic [POS_BITS:0]   ext,
  input  logic                mirror,
  output lane_stat_t          stat,
  output logic [POS_BITS-1:0] pos
);

  localparam int unsigned PW    = RAW_BITS + POS_BITS + 1;
  localparam int unsigned CNT_W = $clog2(PW + 1);

  typedef enum logic [1:0] {
    L_IDLE,
    L_MUL,
    L_DIV
  } lstate_t;

  lstate_t             state_r;
  logic                inwin_r;
  logic [RAW_BITS-1:0] span_r;
  logic [RAW_BITS-1:0] off_r;
  logic [POS_BITS:0]   extm1_r;
  logic [RAW_BITS:0]   rem_r;
  logic [PW-1:0]       quo_r;
  logic [CNT_W-1:0]    cnt_r;

  logic [RAW_BITS-1:0] span;
  logic [RAW_BITS-1:0] off;
  logic [PW-1:0]       prod;
  logic [RAW_BITS:0]   shifted;
  logic [RAW_BITS:0]   diff;
  logic                ge;
  logic [RAW_BITS:0]   rem_nxt;

  assign span    = hi - lo;
  assign off     = raw - lo;
  assign prod    = off_r * extm1_r;
  assign shifted = {rem_r[RAW_BITS-1:0], quo_r[PW-1]};
  assign ge      = shifted >= {1'b0, span_r};
  assign diff    = shifted - {1'b0, span_r};
  assign rem_nxt = ge ? diff : shifted;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
    end else begin
      case (state_r)
        L_IDLE: begin
          if (start) begin
            inwin_r <= (raw >= lo) && (raw <= hi);
            span_r  <= span;
            off_r   <= mirror ? (span - off) : off;
            extm1_r <= ext - 1'b1;
            state_r <= L_MUL;
          end
        end
        L_MUL: begin
          quo_r   <= prod;
          rem_r   <= '0;
          cnt_r   <= '0;
          state_r <= L_DIV;
        end
        L_DIV: begin
          rem_r <= rem_nxt;
          quo_r <= {quo_r[PW-2:0], ge};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(PW - 1)) begin
            state_r <= L_IDLE;
          end
        end
        default: begin
          state_r <= L_IDLE;
        end
      endcase
    end
  end

  // saturate quotients that overflow the position width
  assign pos = (|quo_r[PW-1:POS_BITS]) ? {POS_BITS{1'b1}} : quo_r[POS_BITS-1:0];

  assign stat.busy  = (state_r != L_IDLE);
  assign stat.inwin = inwin_r;

endmodule

// ----- sim/tcat_event_checker.sv -----
// ----------------------------------------------------------------------------
// tcat_event_checker
// Watches the sample, event and register ports of the touch unit. It keeps
// its own copy of the calibration registers and pen tracking state, predicts
// the event for every accepted sample and compares each event transaction
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tcat_event_checker
  import tcat_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  tcat_in_if                   in_mon,
  tcat_out_if                  out_mon,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [12:0]          cfg_wdata,
  output int                   fail_count,
  output int                   pending
);

  localparam logic [11:0] POS_MAX = 12'hFFF;

  typedef struct packed {
    status_t     status;
    phase_t      phase;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
  } touch_event_t;

  logic [11:0]    h_min, h_max, v_min, v_max;
  logic [12:0]    scr_w, scr_h;
  logic [ORI_W-1:0] orient;
  logic           pen_down;
  logic [11:0]    last_x, last_y;
  touch_event_t   expected_events[$];
  touch_event_t   exp_ev;

  task automatic report_mismatch(input string msg);
    $display("[%0t] event mismatch: %s", $time, msg);
    fail_count++;
  endtask

  function automatic logic map_axis(input logic [11:0] raw, lo, hi,
                                    input logic [12:0] extent, input logic mirror,
                                    output logic [11:0] pos);
    logic [11:0] span, off;
    logic [63:0] q;
    pos = '0;
    if (raw < lo || raw > hi) return 1'b0;
    span = hi - lo;
    off  = raw - lo;
    if (mirror) off = span - off;
    q   = (64'(off) * 64'(extent - 13'd1)) / 64'(span);
    pos = (q > POS_MAX) ? POS_MAX : q[11:0];
    return 1'b1;
  endfunction

  function automatic touch_event_t predict_event(input logic touching,
                                                 input logic [11:0] rx, ry);
    touch_event_t ev;
    logic [11:0]  h_raw, v_raw, px, py;
    logic         h_ok, v_ok;
    ev = '0;
    if (h_min >= h_max || v_min >= v_max || scr_w == 0 || scr_h == 0) begin
      ev.status = ST_BAD_CAL;
      return ev;
    end
    h_raw = orient[ORI_SWAP] ? ry : rx;
    v_raw = orient[ORI_SWAP] ? rx : ry;
    h_ok  = map_axis(h_raw, h_min, h_max, scr_w, orient[ORI_INV_H], px);
    v_ok  = map_axis(v_raw, v_min, v_max, scr_h, orient[ORI_INV_V], py);
    if (!(touching && h_ok && v_ok)) begin
      // release or out-of-window sample
      if (pen_down) begin
        ev.status = ST_EVENT;
        ev.phase  = PH_UP;
        ev.pos_x  = last_x;
        ev.pos_y  = last_y;
        pen_down  = 1'b0;
      end
      return ev;
    end
    ev.status = ST_EVENT;
    ev.phase  = pen_down ? PH_MOVE : PH_DOWN;
    ev.pos_x  = px;
    ev.pos_y  = py;
    last_x    = px;
    last_y    = py;
    pen_down  = 1'b1;
    return ev;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      h_min      = '0;
      h_max      = 12'(RST_RAW_MAX);
      v_min      = '0;
      v_max      = 12'(RST_RAW_MAX);
      scr_w      = 13'(RST_WIDTH);
      scr_h      = 13'(RST_HEIGHT);
      orient     = '0;
      pen_down   = 1'b0;
      last_x     = '0;
      last_y     = '0;
      fail_count = 0;
      expected_events.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_events.size() == 0) begin
          report_mismatch($sformatf("unexpected transaction status %0d phase %0d pos %0d,%0d",
                                    out_mon.status, out_mon.phase, out_mon.pos_x,
                                    out_mon.pos_y));
        end else begin
          exp_ev = expected_events.pop_front();
          if (out_mon.status !== exp_ev.status)
            report_mismatch($sformatf("status got %0d want %0d",
                                      out_mon.status, exp_ev.status));
          if (out_mon.phase !== exp_ev.phase)
            report_mismatch($sformatf("phase got %0d want %0d",
                                      out_mon.phase, exp_ev.phase));
          if (out_mon.pos_x !== exp_ev.pos_x)
            report_mismatch($sformatf("pos_x got %0d want %0d",
                                      out_mon.pos_x, exp_ev.pos_x));
          if (out_mon.pos_y !== exp_ev.pos_y)
            report_mismatch($sformatf("pos_y got %0d want %0d",
                                      out_mon.pos_y, exp_ev.pos_y));
        end
      end
      if (cfg_we) begin
        case (cfg_idx)
          REG_HORIZ_MIN:     h_min  = cfg_wdata[11:0];
          REG_HORIZ_MAX:     h_max  = cfg_wdata[11:0];
          REG_VERT_MIN:      v_min  = cfg_wdata[11:0];
          REG_VERT_MAX:      v_max  = cfg_wdata[11:0];
          REG_SCREEN_WIDTH:  scr_w  = cfg_wdata;
          REG_SCREEN_HEIGHT: scr_h  = cfg_wdata;
          REG_ORIENTATION:   orient = cfg_wdata[ORI_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        expected_events.push_back(predict_event(in_mon.touching, in_mon.raw_x,
                                                in_mon.raw_y));
    end
    pending = expected_events.size();
  end

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Testbench top for the touch calibrate and track unit. Drives directed and
// random pen strokes across many calibration settings, with random idling
// on both channels, one long event back-pressure and repeated full drains, and
// reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb;
  import tcat_pkg::*;

  localparam int unsigned         CFG_W        = 13;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 3'd7;
  localparam int                  RAND_PHASES  = 10;
  localparam int                  PHASE_ITEMS  = 100;
  localparam int                  LONG_HOLD    = 300;
  localparam int                  DRAIN_CYCLES = 64;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;
  int                   fail_count;
  int                   pending;
  bit                   quiet_tail;
  bit                   hold_req;

  logic [11:0]      sh_hmin, sh_hmax, sh_vmin, sh_vmax;
  logic [ORI_W-1:0] sh_ori;

  tcat_in_if  #(.RAW_BITS(12)) in_ch ();
  tcat_out_if #(.POS_BITS(12)) out_ch ();

  touch_calibrate_and_track_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  tcat_event_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // event receiver: random stalls, one long hold on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_sample(input logic t, input logic [11:0] x, y);
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 8)) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_ch.valid    <= 1'b1;
    in_ch.touching <= t;
    in_ch.raw_x    <= x;
    in_ch.raw_y    <= y;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait (pending == 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic configure(input logic [11:0] hmin, hmax, vmin, vmax,
                           input logic [12:0] w, h, input logic [ORI_W-1:0] ori);
    wait_drained();
    // upper data bit is dropped by the 12-bit registers
    write_reg(REG_HORIZ_MIN, {1'($urandom_range(0, 1)), hmin});
    write_reg(REG_HORIZ_MAX, {1'($urandom_range(0, 1)), hmax});
    write_reg(REG_VERT_MIN, {1'($urandom_range(0, 1)), vmin});
    write_reg(REG_VERT_MAX, {1'($urandom_range(0, 1)), vmax});
    write_reg(REG_SCREEN_WIDTH, w);
    write_reg(REG_SCREEN_HEIGHT, h);
    write_reg(REG_ORIENTATION, {10'($urandom_range(0, 1023)), ori});
    write_reg(REG_UNUSED, 13'($urandom_range(0, 8191)));
    sh_hmin = hmin;
    sh_hmax = hmax;
    sh_vmin = vmin;
    sh_vmax = vmax;
    sh_ori  = ori;
  endtask

  function automatic logic [11:0] pick_raw(input logic [11:0] lo, hi);
    case ($urandom_range(0, 7))
      0:       return lo;
      1:       return hi;
      default: return 12'($urandom_range(lo, hi));
    endcase
  endfunction

  function automatic bit pick_outside(input logic [11:0] lo, hi, inout logic [11:0] v);
    if (lo > 0 && (hi == 12'hFFF || $urandom_range(0, 1) == 0)) begin
      v = 12'($urandom_range(0, lo - 1));
      return 1'b1;
    end
    if (hi < 12'hFFF) begin
      v = 12'($urandom_range(hi + 1, 4095));
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic random_config();
    logic [11:0] a, b, c, d;
    logic [12:0] w, h;
    case ($urandom_range(0, 4))
      0: begin
        a = 0; b = 12'hFFF; c = 0; d = 12'hFFF;
      end
      1: begin
        a = 12'($urandom_range(0, 4094)); b = a + 1;
        c = 12'($urandom_range(0, 4094)); d = c + 1;
      end
      default: begin
        a = 12'($urandom_range(0, 4094)); b = 12'($urandom_range(a + 1, 4095));
        c = 12'($urandom_range(0, 4094)); d = 12'($urandom_range(c + 1, 4095));
      end
    endcase
    case ($urandom_range(0, 5))
      0:       begin w = 13'($urandom_range(4097, 8191)); h = 13'($urandom_range(4097, 8191)); end
      1:       begin w = 1; h = 4096; end
      default: begin w = 13'($urandom_range(1, 4096)); h = 13'($urandom_range(1, 4096)); end
    endcase
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0: b = a;
        1: d = 12'($urandom_range(0, c));
        2: w = 0;
        default: h = 0;
      endcase
    end
    configure(a, b, c, d, w, h, ORI_W'($urandom_range(0, 7)));
  endtask

  task automatic random_phase(input int p);
    int          n;
    bit          held, paused;
    logic [11:0] x, y, xlo, xhi, ylo, yhi;
    n      = 0;
    held   = 0;
    paused = 0;
    xlo = sh_ori[ORI_SWAP] ? sh_vmin : sh_hmin;
    xhi = sh_ori[ORI_SWAP] ? sh_vmax : sh_hmax;
    ylo = sh_ori[ORI_SWAP] ? sh_hmin : sh_vmin;
    yhi = sh_ori[ORI_SWAP] ? sh_hmax : sh_vmax;
    while (n < PHASE_ITEMS) begin
      if (p == 3 && n >= 30 && !held) begin
        held     = 1;
        hold_req = 1'b1;
      end
      if (p == 5 && n >= 50 && !paused) begin
        paused = 1;
        wait_drained();
      end
      if ($urandom_range(0, 4) == 0) begin
        send_sample(1'($urandom_range(0, 1)), 12'($urandom_range(0, 4095)),
                    12'($urandom_range(0, 4095)));
        n++;
      end else begin
        repeat ($urandom_range(1, 12)) begin
          send_sample(1'b1, pick_raw(xlo, xhi), pick_raw(ylo, yhi));
          n++;
        end
        x = pick_raw(xlo, xhi);
        y = pick_raw(ylo, yhi);
        if ($urandom_range(0, 1) && (pick_outside(xlo, xhi, x) || pick_outside(ylo, yhi, y)))
          send_sample(1'b1, x, y);
        else
          send_sample(1'b0, 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
        n++;
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = '0;
    cfg_wdata      = '0;
    in_ch.valid    = 1'b0;
    in_ch.touching = 1'b0;
    in_ch.raw_x    = '0;
    in_ch.raw_y    = '0;
    out_ch.ready   = 1'b0;
    quiet_tail     = 1'b0;
    hold_req       = 1'b0;
    sh_hmin = 0; sh_hmax = 12'hFFF; sh_vmin = 0; sh_vmax = 12'hFFF; sh_ori = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // default calibration: down, moves, up, release while idle
    send_sample(1'b1, 12'h000, 12'h000);
    send_sample(1'b1, 12'hFFF, 12'hFFF);
    send_sample(1'b1, 12'hAAA, 12'h555);
    send_sample(1'b0, 12'hFFF, 12'h000);
    send_sample(1'b0, 12'h000, 12'hFFF);
    send_sample(1'b1, 12'd2048, 12'd1024);

    // narrow window, oversized height saturates; pen stays down across writes
    configure(12'd100, 12'd3000, 12'd200, 12'd3900, 13'd4096, 13'd8191, 3'b000);
    send_sample(1'b1, 12'd100, 12'd200);
    send_sample(1'b1, 12'd3000, 12'd3900);
    send_sample(1'b1, 12'd99, 12'd500);
    send_sample(1'b1, 12'd4000, 12'd500);
    send_sample(1'b1, 12'd500, 12'd199);
    send_sample(1'b1, 12'd500, 12'd3901);
    send_sample(1'b1, 12'd1550, 12'd2050);

    // one-step span, unit width, swapped and mirrored
    configure(12'd4094, 12'd4095, 12'd0, 12'd4095, 13'd1, 13'd4096, 3'b111);
    send_sample(1'b1, 12'd4095, 12'd4094);
    send_sample(1'b1, 12'd0, 12'd4095);

    // bad calibration leaves tracking untouched
    configure(12'd2000, 12'd2000, 12'd0, 12'd4095, 13'd320, 13'd240, 3'b000);
    send_sample(1'b1, 12'd2000, 12'd5);
    configure(12'd3000, 12'd1000, 12'd0, 12'd4095, 13'd320, 13'd240, 3'b000);
    send_sample(1'b0, 12'd1, 12'd2);
    configure(12'd0, 12'd4095, 12'd0, 12'd4095, 13'd0, 13'd240, 3'b000);
    send_sample(1'b1, 12'd7, 12'd9);
    configure(12'd0, 12'd4095, 12'd0, 12'd4095, 13'd320, 13'd0, 3'b000);
    send_sample(1'b1, 12'd7, 12'd9);
    configure(12'd0, 12'd4095, 12'd4095, 12'd4095, 13'd320, 13'd240, 3'b000);
    send_sample(1'b1, 12'd7, 12'd9);

    configure(12'd0, 12'd4095, 12'd0, 12'd4095, 13'd4096, 13'd4096, 3'b010);
    send_sample(1'b1, 12'd4095, 12'd0);
    send_sample(1'b0, 12'd0, 12'd0);
    send_sample(1'b1, 12'd0, 12'd4095);
    send_sample(1'b0, 12'd0, 12'd0);

    for (int p = 0; p < RAND_PHASES; p++) begin
      random_config();
      if (p == RAND_PHASES - 1) begin
        @(posedge clk);
        quiet_tail = 1'b1;
      end
      random_phase(p);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
